// ===== design/ccd_pkg.sv =====
// package for the cluster cache directory: codes, types and constants
`timescale 1ns / 1ps

package ccd_pkg;

  localparam int ENTRIES_DEF = 16;
  localparam int CLUSTER_W   = 32;
  localparam int SLOT_W      = 4;
  localparam int LFSR_W      = 16;

  localparam logic [LFSR_W-1:0] LFSR_SEED = 16'h0001;
  localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;

  // request kinds as carried on in_tuser
  typedef enum logic [1:0] {
    ACT_READ  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_INVAL = 2'd2,
    ACT_FLUSH = 2'd3
  } action_t;

  // sequencer states, one-hot
  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_SCAN   = 8'b0000_0010,
    S_VICTIM = 8'b0000_0100,
    S_VREAD  = 8'b0000_1000,
    S_FCOUNT = 8'b0001_0000,
    S_FFIND  = 8'b0010_0000,
    S_FREAD  = 8'b0100_0000,
    S_RESULT = 8'b1000_0000
  } state_t;

  // status of the victim picker
  typedef struct packed {
    logic busy;
    logic done;
  } vic_status_t;

endpackage

// ===== design/ccd_tag_ram.sv =====
// tag memory: one write port, one registered read port
`timescale 1ns / 1ps

module ccd_tag_ram #(
  parameter int ENTRIES = ccd_pkg::ENTRIES_DEF,
  localparam int IW = $clog2(ENTRIES)
) (
  input  logic                           clk,
  input  logic                           wr_en,
  input  logic [IW-1:0]                  wr_addr,
  input  logic [ccd_pkg::CLUSTER_W-1:0]  wr_data,
  input  logic [IW-1:0]                  rd_addr,
  output logic [ccd_pkg::CLUSTER_W-1:0]  rd_data
);

  logic [ccd_pkg::CLUSTER_W-1:0] mem [ENTRIES];
  logic [ccd_pkg::CLUSTER_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== design/ccd_victim_gen.sv =====
// victim picker: lfsr advance then remainder by the slot count through a reciprocal multiply
`timescale 1ns / 1ps

module ccd_victim_gen #(
  parameter int ENTRIES = ccd_pkg::ENTRIES_DEF,
  localparam int IW = $clog2(ENTRIES),
  localparam int LW = ccd_pkg::LFSR_W,
  localparam int SH = LW + IW,
  localparam int MW = LW + 1,
  localparam int PW = LW + MW
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output ccd_pkg::vic_status_t  status,
  output logic [IW-1:0]         victim_idx
);

  // ceil(2^SH / ENTRIES): exact quotient for every LW-bit value
  localparam logic [MW-1:0] RECIP =
    MW'(((64'd1 << SH) + 64'(ENTRIES) - 64'd1) / 64'(ENTRIES));

  logic [LW-1:0] lfsr_r, lfsr_nxt;
  logic [LW-1:0] val_r, val_nxt;
  logic [LW-1:0] quo_r, quo_nxt;
  logic [IW-1:0] rem_r, rem_nxt;
  logic          step_r, step_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [LW-1:0] lfsr_adv;
  logic [PW-1:0] prod;
  logic [LW-1:0] back;

  // galois step
  assign lfsr_adv = lfsr_r[0] ? ((lfsr_r >> 1) ^ ccd_pkg::LFSR_TAPS) : (lfsr_r >> 1);
  assign prod     = PW'(val_r) * PW'(RECIP);
  // quotient times slot count never exceeds the value, so no overflow
  assign back     = quo_r * LW'(ENTRIES);

  always_comb begin
    lfsr_nxt = lfsr_r;
    val_nxt  = val_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      lfsr_nxt = lfsr_adv;
      val_nxt  = lfsr_adv;
      step_nxt = 1'b0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!step_r) begin
        // quotient from the reciprocal product
        quo_nxt  = LW'(prod >> SH);
        step_nxt = 1'b1;
      end else begin
        // remainder, exact so no correction step
        rem_nxt  = IW'(val_r - back);
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lfsr_r <= ccd_pkg::LFSR_SEED;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      lfsr_r <= lfsr_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r  <= val_nxt;
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    step_r <= step_nxt;
  end

  assign status.busy = busy_r;
  assign status.done = done_r;
  assign victim_idx  = rem_r;

endmodule

// ===== design/cluster_cache_directory.sv =====
// top level of the cluster cache directory: sequencer, slot flags and result register
`timescale 1ns / 1ps

// channel  direction  ports                          contents
// in       slave      in_tvalid/in_tready            in_tdata: cluster_number, in_tuser: action
// out      master     out_tvalid/out_tready/tlast    out_tdata: slot, write_back_cluster,
//                                                    out_tuser: hit, write_back, nothing_done
//
// read, write, invalidate: one tag compared per cycle in slot order, read pipelined
//   through the tag memory; a miss scans every slot, a hit ends the scan early
// a miss with every slot valid and dirty adds a victim pick: lfsr step, reciprocal
//   quotient and remainder, then the victim tag read
// flush: a counting pass over every slot, then a find pass that stops on each dirty
//   slot to read its tag; one result per dirty slot, or one nothing_done result if none
// reset clears the valid and dirty flags; tags need no clear
// in_tready is high only while idle; a result waiting on out_tready stalls
//   the next load of the result register, and the sequencer waits in its result state

module cluster_cache_directory #(
  parameter int ENTRIES = ccd_pkg::ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] cluster_number
  input  logic [1:0]  in_tuser,   // [1:0] action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [3:0] slot, [35:4] write_back_cluster, [39:36] zero
  output logic [2:0]  out_tuser,  // [0] hit, [1] write_back, [2] nothing_done
  output logic        out_tlast
);

  localparam int IW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int TW = ccd_pkg::CLUSTER_W;

  ccd_pkg::state_t  state_r, state_nxt;
  ccd_pkg::action_t act_r, act_nxt;

  logic [TW-1:0]      clu_r, clu_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [CW-1:0]      fcount_r, fcount_nxt;
  logic               pipe_r, pipe_nxt;
  logic               cmp_vld_r, cmp_vld_nxt;
  logic [IW-1:0]      cmp_idx_r, cmp_idx_nxt;
  logic               inv_fnd_r, inv_fnd_nxt;
  logic [IW-1:0]      inv_idx_r, inv_idx_nxt;
  logic               cln_fnd_r, cln_fnd_nxt;
  logic [IW-1:0]      cln_idx_r, cln_idx_nxt;
  logic               hit_r, hit_nxt;
  logic [IW-1:0]      slot_r, slot_nxt;
  logic               wb_r, wb_nxt;
  logic [TW-1:0]      wbc_r, wbc_nxt;
  logic               none_r, none_nxt;
  logic               last_r, last_nxt;
  logic [ENTRIES-1:0] valid_r, valid_nxt;
  logic [ENTRIES-1:0] dirty_r, dirty_nxt;

  logic [IW-1:0] idx;
  logic [IW-1:0] rd_addr;
  logic [TW-1:0] tag_rd;
  logic          wr_en;
  logic [TW-1:0] wr_data;
  logic          vic_start;
  logic [IW-1:0] vic_idx;
  logic          out_free;
  logic          out_load;

  ccd_pkg::vic_status_t vic_status;

  // result register
  logic                       out_valid_r;
  logic [ccd_pkg::SLOT_W-1:0] out_slot_r;
  logic [TW-1:0]              out_wbc_r;
  logic                       out_hit_r;
  logic                       out_wb_r;
  logic                       out_none_r;
  logic                       out_last_r;

  assign idx      = cnt_r[IW-1:0];
  assign out_free = !out_valid_r || out_tready;

  ccd_tag_ram #(.ENTRIES(ENTRIES)) u_tag_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (slot_r),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (tag_rd)
  );

  ccd_victim_gen #(.ENTRIES(ENTRIES)) u_victim (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (vic_start),
    .status     (vic_status),
    .victim_idx (vic_idx)
  );

  always_comb begin
    state_nxt   = state_r;
    act_nxt     = act_r;
    clu_nxt     = clu_r;
    cnt_nxt     = cnt_r;
    fcount_nxt  = fcount_r;
    pipe_nxt    = pipe_r;
    cmp_vld_nxt = cmp_vld_r;
    cmp_idx_nxt = cmp_idx_r;
    inv_fnd_nxt = inv_fnd_r;
    inv_idx_nxt = inv_idx_r;
    cln_fnd_nxt = cln_fnd_r;
    cln_idx_nxt = cln_idx_r;
    hit_nxt     = hit_r;
    slot_nxt    = slot_r;
    wb_nxt      = wb_r;
    wbc_nxt     = wbc_r;
    none_nxt    = none_r;
    last_nxt    = last_r;
    valid_nxt   = valid_r;
    dirty_nxt   = dirty_r;
    rd_addr     = idx;
    wr_en       = 1'b0;
    wr_data     = clu_r;
    vic_start   = 1'b0;
    out_load    = 1'b0;

    case (state_r)
      ccd_pkg::S_IDLE: begin
        if (in_tvalid) begin
          act_nxt     = ccd_pkg::action_t'(in_tuser);
          clu_nxt     = in_tdata;
          cnt_nxt     = '0;
          fcount_nxt  = '0;
          pipe_nxt    = 1'b0;
          inv_fnd_nxt = 1'b0;
          cln_fnd_nxt = 1'b0;
          hit_nxt     = 1'b0;
          slot_nxt    = '0;
          wb_nxt      = 1'b0;
          wbc_nxt     = '0;
          none_nxt    = 1'b0;
          last_nxt    = 1'b1;
          state_nxt   = (ccd_pkg::action_t'(in_tuser) == ccd_pkg::ACT_FLUSH) ?
                        ccd_pkg::S_FCOUNT : ccd_pkg::S_SCAN;
        end
      end

      ccd_pkg::S_SCAN: begin
        // issue stage: read tag, note first free and first clean slot
        pipe_nxt = 1'b0;
        if (cnt_r < CW'(ENTRIES)) begin
          pipe_nxt    = 1'b1;
          cmp_vld_nxt = valid_r[idx];
          cmp_idx_nxt = idx;
          cnt_nxt     = cnt_r + 1'b1;
          if (!valid_r[idx] && !inv_fnd_r) begin
            inv_fnd_nxt = 1'b1;
            inv_idx_nxt = idx;
          end
          if (!dirty_r[idx] && !cln_fnd_r) begin
            cln_fnd_nxt = 1'b1;
            cln_idx_nxt = idx;
          end
        end
        // compare stage: the shared tag comparator
        if (pipe_r && cmp_vld_r && (tag_rd == clu_r)) begin
          hit_nxt   = 1'b1;
          slot_nxt  = cmp_idx_r;
          state_nxt = ccd_pkg::S_RESULT;
        end else if (!pipe_r && (cnt_r == CW'(ENTRIES))) begin
          if (act_r == ccd_pkg::ACT_INVAL) begin
            none_nxt  = 1'b1;
            slot_nxt  = '0;
            state_nxt = ccd_pkg::S_RESULT;
          end else if (inv_fnd_r) begin
            slot_nxt  = inv_idx_r;
            state_nxt = ccd_pkg::S_RESULT;
          end else if (cln_fnd_r) begin
            slot_nxt  = cln_idx_r;
            state_nxt = ccd_pkg::S_RESULT;
          end else begin
            vic_start = 1'b1;
            state_nxt = ccd_pkg::S_VICTIM;
          end
        end
      end

      ccd_pkg::S_VICTIM: begin
        if (vic_status.done) begin
          rd_addr   = vic_idx;
          slot_nxt  = vic_idx;
          state_nxt = ccd_pkg::S_VREAD;
        end
      end

      ccd_pkg::S_VREAD: begin
        wb_nxt    = 1'b1;
        wbc_nxt   = tag_rd;
        state_nxt = ccd_pkg::S_RESULT;
      end

      ccd_pkg::S_FCOUNT: begin
        if (cnt_r < CW'(ENTRIES)) begin
          if (valid_r[idx] && dirty_r[idx]) begin
            fcount_nxt = fcount_r + 1'b1;
          end
          cnt_nxt = cnt_r + 1'b1;
        end else if (fcount_r == '0) begin
          none_nxt  = 1'b1;
          state_nxt = ccd_pkg::S_RESULT;
        end else begin
          cnt_nxt   = '0;
          state_nxt = ccd_pkg::S_FFIND;
        end
      end

      ccd_pkg::S_FFIND: begin
        if (cnt_r < CW'(ENTRIES)) begin
          cnt_nxt = cnt_r + 1'b1;
          if (valid_r[idx] && dirty_r[idx]) begin
            slot_nxt  = idx;
            state_nxt = ccd_pkg::S_FREAD;
          end
        end else begin
          state_nxt = ccd_pkg::S_IDLE;
        end
      end

      ccd_pkg::S_FREAD: begin
        wb_nxt    = 1'b1;
        wbc_nxt   = tag_rd;
        last_nxt  = (fcount_r == CW'(1));
        state_nxt = ccd_pkg::S_RESULT;
      end

      ccd_pkg::S_RESULT: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = ccd_pkg::S_IDLE;
          case (act_r)
            ccd_pkg::ACT_READ, ccd_pkg::ACT_WRITE: begin
              if (hit_r) begin
                if (act_r == ccd_pkg::ACT_WRITE) begin
                  dirty_nxt[slot_r] = 1'b1;
                end
              end else begin
                valid_nxt[slot_r] = 1'b1;
                dirty_nxt[slot_r] = (act_r == ccd_pkg::ACT_WRITE);
                wr_en             = 1'b1;
              end
            end
            ccd_pkg::ACT_INVAL: begin
              if (hit_r) begin
                valid_nxt[slot_r] = 1'b0;
                dirty_nxt[slot_r] = 1'b0;
                wr_en             = 1'b1;
                wr_data           = '0;
              end
            end
            ccd_pkg::ACT_FLUSH: begin
              if (!none_r) begin
                dirty_nxt[slot_r] = 1'b0;
                fcount_nxt        = fcount_r - 1'b1;
                if (!last_r) begin
                  state_nxt = ccd_pkg::S_FFIND;
                end
              end
            end
            default: begin
              state_nxt = ccd_pkg::S_IDLE;
            end
          endcase
        end
      end

      default: begin
        state_nxt = ccd_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ccd_pkg::S_IDLE;
      valid_r     <= '0;
      dirty_r     <= '0;
      pipe_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
      dirty_r <= dirty_nxt;
      pipe_r  <= pipe_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk) begin
    act_r     <= act_nxt;
    clu_r     <= clu_nxt;
    cnt_r     <= cnt_nxt;
    fcount_r  <= fcount_nxt;
    cmp_vld_r <= cmp_vld_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    inv_fnd_r <= inv_fnd_nxt;
    inv_idx_r <= inv_idx_nxt;
    cln_fnd_r <= cln_fnd_nxt;
    cln_idx_r <= cln_idx_nxt;
    hit_r     <= hit_nxt;
    slot_r    <= slot_nxt;
    wb_r      <= wb_nxt;
    wbc_r     <= wbc_nxt;
    none_r    <= none_nxt;
    last_r    <= last_nxt;
  end

  // result payload, loaded when the register is free
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_slot_r <= ccd_pkg::SLOT_W'(slot_r);
      out_wbc_r  <= wbc_r;
      out_hit_r  <= hit_r;
      out_wb_r   <= wb_r;
      out_none_r <= none_r;
      out_last_r <= last_r;
    end
  end

  assign in_tready  = (state_r == ccd_pkg::S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_wbc_r, out_slot_r};
  assign out_tuser  = {out_none_r, out_wb_r, out_hit_r};
  assign out_tlast  = out_last_r;

endmodule

// ===== design/ccd_checker.sv =====
// port-level checker for the cluster cache directory, bound to the top level
`timescale 1ns / 1ps

module ccd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [31:0] in_tdata,
  input logic [1:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic [2:0]  out_tuser,
  input logic        out_tlast
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser)
                                  && $stable(out_tlast))
    else $error("stalled result changed");

  // one request at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input ready right after a transfer");

  // an empty result carries no hit, no write-back, slot zero, and ends the request
  a_nothing_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2] |-> !out_tuser[0] && !out_tuser[1]
                                   && (out_tdata[3:0] == 4'd0) && out_tlast)
    else $error("bad nothing-done result");

  // write-back cluster is zero without write-back, and a hit never writes back
  a_wb_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[0] && out_tuser[1])
                   && (out_tuser[1] || (out_tdata[35:4] == 32'd0)))
    else $error("bad write-back fields");

endmodule

bind cluster_cache_directory ccd_checker u_ccd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

// ===== tb/ccd_checker.sv =====
// checker for the cluster cache directory: slot directory predictor and result compare
`timescale 1ns / 1ps

module ccd_scoreboard #(
  parameter int ENTRIES = ccd_pkg::ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,
  input  logic [2:0]  out_tuser,
  input  logic        out_tlast,
  output int          mismatches,
  output int          outstanding,
  output int          results_checked,
  output int          lfsr_evictions
);

  typedef struct packed {
    logic        hit;
    logic [3:0]  slot;
    logic        write_back;
    logic [31:0] wb_cluster;
    logic        nothing_done;
    logic        last;
  } dir_result_t;

  logic                       dir_valid [ENTRIES];
  logic                       dir_dirty [ENTRIES];
  logic [31:0]                dir_tag   [ENTRIES];
  logic [ccd_pkg::LFSR_W-1:0] victim_state;
  dir_result_t                due_results [$];

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: mismatch in %s: got %h, want %h", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic push_result(input logic hit, input int slot, input logic wb,
                             input logic [31:0] wbc, input logic none, input logic last);
    dir_result_t r;
    r.hit          = hit;
    r.slot         = slot[3:0];
    r.write_back   = wb;
    r.wb_cluster   = wbc;
    r.nothing_done = none;
    r.last         = last;
    due_results.push_back(r);
  endtask

  // walks the directory the way the block does and queues every result of one request
  task automatic predict_request(input ccd_pkg::action_t act, input logic [31:0] cluster);
    int          i;
    int          found;
    int          pick;
    int          dirty_total;
    int          emitted;
    logic        wb;
    logic [31:0] wbc;
    found = -1;
    pick  = -1;
    wb    = 1'b0;
    wbc   = '0;
    for (i = 0; i < ENTRIES; i++)
      if (found < 0 && dir_valid[i] && dir_tag[i] == cluster) found = i;
    case (act)
      ccd_pkg::ACT_READ, ccd_pkg::ACT_WRITE: begin
        if (found >= 0) begin
          if (act == ccd_pkg::ACT_WRITE) dir_dirty[found] = 1'b1;
          push_result(1'b1, found, 1'b0, '0, 1'b0, 1'b1);
        end else begin
          for (i = 0; i < ENTRIES; i++)
            if (pick < 0 && !dir_valid[i]) pick = i;
          for (i = 0; i < ENTRIES; i++)
            if (pick < 0 && !dir_dirty[i]) pick = i;
          if (pick < 0) begin
            // all slots dirty: step the galois lfsr once, victim is its remainder
            victim_state = victim_state[0] ? ((victim_state >> 1) ^ ccd_pkg::LFSR_TAPS)
                                           : (victim_state >> 1);
            pick = int'(victim_state) % ENTRIES;
            wb   = 1'b1;
            wbc  = dir_tag[pick];
            lfsr_evictions++;
          end
          dir_valid[pick] = 1'b1;
          dir_tag[pick]   = cluster;
          dir_dirty[pick] = (act == ccd_pkg::ACT_WRITE);
          push_result(1'b0, pick, wb, wbc, 1'b0, 1'b1);
        end
      end
      ccd_pkg::ACT_INVAL: begin
        if (found < 0) begin
          push_result(1'b0, 0, 1'b0, '0, 1'b1, 1'b1);
        end else begin
          dir_valid[found] = 1'b0;
          dir_dirty[found] = 1'b0;
          dir_tag[found]   = '0;
          push_result(1'b1, found, 1'b0, '0, 1'b0, 1'b1);
        end
      end
      default: begin
        dirty_total = 0;
        emitted     = 0;
        for (i = 0; i < ENTRIES; i++)
          if (dir_valid[i] && dir_dirty[i]) dirty_total++;
        if (dirty_total == 0) begin
          push_result(1'b0, 0, 1'b0, '0, 1'b1, 1'b1);
        end else begin
          for (i = 0; i < ENTRIES; i++) begin
            if (dir_valid[i] && dir_dirty[i]) begin
              emitted++;
              push_result(1'b0, i, 1'b1, dir_tag[i], 1'b0, emitted == dirty_total);
              dir_dirty[i] = 1'b0;
            end
          end
        end
      end
    endcase
  endtask

  always @(posedge clk) begin : watch
    dir_result_t got;
    dir_result_t want;
    int          i;
    if (!rst_n) begin
      for (i = 0; i < ENTRIES; i++) begin
        dir_valid[i] = 1'b0;
        dir_dirty[i] = 1'b0;
        dir_tag[i]   = '0;
      end
      victim_state = ccd_pkg::LFSR_SEED;
      due_results.delete();
      outstanding = 0;
    end else begin
      if (in_tvalid && in_tready)
        predict_request(ccd_pkg::action_t'(in_tuser), in_tdata);
      if (out_tvalid && out_tready) begin
        got.hit          = out_tuser[0];
        got.slot         = out_tdata[3:0];
        got.write_back   = out_tuser[1];
        got.wb_cluster   = out_tdata[35:4];
        got.nothing_done = out_tuser[2];
        got.last         = out_tlast;
        if (due_results.size() == 0) begin
          report_mismatch("result with nothing pending, slot", 32'(got.slot), '0);
        end else begin
          want = due_results.pop_front();
          results_checked++;
          if (got.hit !== want.hit) report_mismatch("hit", 32'(got.hit), 32'(want.hit));
          if (got.slot !== want.slot) report_mismatch("slot", 32'(got.slot), 32'(want.slot));
          if (got.write_back !== want.write_back)
            report_mismatch("write_back", 32'(got.write_back), 32'(want.write_back));
          if (got.wb_cluster !== want.wb_cluster)
            report_mismatch("write_back_cluster", got.wb_cluster, want.wb_cluster);
          if (got.nothing_done !== want.nothing_done)
            report_mismatch("nothing_done", 32'(got.nothing_done), 32'(want.nothing_done));
          if (got.last !== want.last) report_mismatch("last", 32'(got.last), 32'(want.last));
          if (out_tdata[39:36] !== 4'b0)
            report_mismatch("tdata padding", 32'(out_tdata[39:36]), '0);
        end
      end
      outstanding = due_results.size();
    end
  end

endmodule

// ===== tb/cluster_cache_directory_tb.sv =====
// testbench top for the cluster cache directory: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module cluster_cache_directory_tb;

  localparam int ENTRIES     = ccd_pkg::ENTRIES_DEF;
  localparam int RANDOM_REQS = 410;
  // worst item: full scan plus the lfsr victim pick, or a flush of every slot with
  // each result held by a long receiver stall; many times over for margin
  localparam int CYCLE_LIMIT = 600000;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;
  logic [1:0]  in_tuser   = ccd_pkg::ACT_READ;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;

  int mismatches;
  int outstanding;
  int results_checked;
  int lfsr_evictions;

  int          cycle_count;
  int          burst_left;
  int          ready_mode;
  int          ready_span;
  int          req_count [4];
  logic [31:0] cluster_pool [64];

  // 8 ns clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  cluster_cache_directory #(.ENTRIES(ENTRIES)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  ccd_scoreboard #(.ENTRIES(ENTRIES)) u_scoreboard (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .out_tlast       (out_tlast),
    .mismatches      (mismatches),
    .outstanding     (outstanding),
    .results_checked (results_checked),
    .lfsr_evictions  (lfsr_evictions)
  );

  // run watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending", cycle_count, outstanding);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // receiver: spans of always-ready, light stalls or heavy stalls, each of random length
  always @(negedge clk) begin
    if (ready_span == 0) begin
      ready_mode = $urandom_range(0, 2);
      ready_span = $urandom_range(20, 150);
    end
    ready_span--;
    case (ready_mode)
      0:       out_tready <= 1'b1;
      1:       out_tready <= ($urandom_range(0, 3) != 0);
      default: out_tready <= ($urandom_range(0, 9) < 3);
    endcase
  end

  // one request transfer; afterwards either stay valid for the next one in the burst
  // or drop valid for a random gap, driving junk on the data lines meanwhile
  task automatic send_req(input ccd_pkg::action_t act, input logic [31:0] cluster);
    int gap;
    in_tuser  = act;
    in_tdata  = cluster;
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    req_count[act]++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_tvalid = 1'b0;
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 20) : $urandom_range(1, 3);
      repeat (gap) begin
        in_tdata = $urandom;
        in_tuser = 2'($urandom);
        @(negedge clk);
      end
      burst_left = $urandom_range(0, 6);
    end
  endtask

  initial begin : stimulus
    int               k;
    int               pool_size;
    int               phase_len;
    int               phase_kind;
    int               roll;
    int               sent;
    ccd_pkg::action_t act;
    logic [31:0]      cluster;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: empty flush, invalidate of cluster 0 while every slot is still invalid,
    // extreme cluster numbers, hits and misses of each kind
    send_req(ccd_pkg::ACT_FLUSH, 32'h0);
    send_req(ccd_pkg::ACT_INVAL, 32'h0);
    send_req(ccd_pkg::ACT_READ,  32'h0);
    send_req(ccd_pkg::ACT_READ,  32'hFFFF_FFFF);
    send_req(ccd_pkg::ACT_READ,  32'h0);
    send_req(ccd_pkg::ACT_WRITE, 32'hFFFF_FFFF);
    send_req(ccd_pkg::ACT_INVAL, 32'h0);
    send_req(ccd_pkg::ACT_INVAL, 32'h0);
    send_req(ccd_pkg::ACT_FLUSH, 32'hFFFF_FFFF);
    send_req(ccd_pkg::ACT_FLUSH, 32'h0);
    // fill every free slot dirty, leaving the flushed one valid but clean
    for (k = 0; k < ENTRIES - 1; k++) send_req(ccd_pkg::ACT_WRITE, 32'h8000_0000 | k);
    // first clean slot gets reused, then a full dirty directory forces an lfsr victim
    send_req(ccd_pkg::ACT_WRITE, 32'h1234_5678);
    send_req(ccd_pkg::ACT_WRITE, 32'hA5A5_0000);
    // flush with every slot dirty: one result per slot
    send_req(ccd_pkg::ACT_FLUSH, 32'h0);

    // random: phases over a pool of clusters so hits, refills and evictions recur;
    // churn phases write heavily to keep the directory full and dirty, and some pools
    // are larger than it; mixed phases exercise invalidate and flush more
    sent = 0;
    while (sent < RANDOM_REQS) begin
      case ($urandom_range(0, 4))
        0:       pool_size = 6;
        1:       pool_size = 12;
        2:       pool_size = ENTRIES;
        3:       pool_size = ENTRIES + 4;
        default: pool_size = 40;
      endcase
      for (k = 0; k < pool_size; k++) cluster_pool[k] = $urandom;
      if ($urandom_range(0, 3) == 0) cluster_pool[0] = 32'h0;
      if ($urandom_range(0, 3) == 0) cluster_pool[pool_size - 1] = 32'hFFFF_FFFF;
      phase_kind = $urandom_range(0, 1);
      phase_len  = $urandom_range(30, 80);
      for (k = 0; k < phase_len && sent < RANDOM_REQS; k++) begin
        roll = $urandom_range(0, 99);
        if (phase_kind == 0)
          act = (roll < 25) ? ccd_pkg::ACT_READ : (roll < 95) ? ccd_pkg::ACT_WRITE :
                (roll < 98) ? ccd_pkg::ACT_INVAL : ccd_pkg::ACT_FLUSH;
        else
          act = (roll < 35) ? ccd_pkg::ACT_READ : (roll < 70) ? ccd_pkg::ACT_WRITE :
                (roll < 90) ? ccd_pkg::ACT_INVAL : ccd_pkg::ACT_FLUSH;
        // mostly pool members, some stray clusters that only ever miss
        cluster = ($urandom_range(0, 9) == 0) ? $urandom
                                              : cluster_pool[$urandom_range(0, pool_size - 1)];
        send_req(act, cluster);
        sent++;
      end
    end

    // drain, then allow a flush worth of cycles for anything unforeseen
    in_tvalid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (8 * ENTRIES + 60) @(negedge clk);

    $display("ran %0d requests: %0d read, %0d write, %0d invalidate, %0d flush",
             req_count[ccd_pkg::ACT_READ] + req_count[ccd_pkg::ACT_WRITE] +
             req_count[ccd_pkg::ACT_INVAL] + req_count[ccd_pkg::ACT_FLUSH],
             req_count[ccd_pkg::ACT_READ], req_count[ccd_pkg::ACT_WRITE],
             req_count[ccd_pkg::ACT_INVAL], req_count[ccd_pkg::ACT_FLUSH]);
    $display("%0d results compared, %0d dirty victims picked by the lfsr, %0d errors",
             results_checked, lfsr_evictions, mismatches);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
